### design/tcgea_pkg.sv
`timescale 1ns / 1ps

package tcgea_pkg;

  // Default counter width for the occupancy, waiter and streak counters.
  localparam int COUNT_BITS_DEF = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STREAK_LIMIT = 2'd1;

  localparam logic [CFG_DATA_W-1:0] CAPACITY_RST     = 8'd4;
  localparam logic [CFG_DATA_W-1:0] STREAK_LIMIT_RST = 8'd8;

  // Result status codes.
  localparam logic [2:0] ST_GRANTED   = 3'd0;
  localparam logic [2:0] ST_QUEUED    = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_LEFT      = 3'd3;
  localparam logic [2:0] ST_LEAVE_ERR = 3'd4;

  // Owner and wake class codes.
  localparam logic [1:0] OWN_NONE = 2'd0;
  localparam logic [1:0] OWN_A    = 2'd1;
  localparam logic [1:0] OWN_B    = 2'd2;

  localparam logic OP_ENTER = 1'b0;
  localparam logic OP_LEAVE = 1'b1;

  typedef struct packed {
    logic operation;
    logic group;
  } in_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [1:0] wake_group;
    logic [7:0] wake_count;
  } out_rsp_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] capacity;
    logic [CFG_DATA_W-1:0] streak_limit;
  } cfg_t;

endpackage

### design/tcgea_core.sv
`timescale 1ns / 1ps

module tcgea_core #(
  parameter int COUNT_BITS = tcgea_pkg::COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               req_accept,
  input  tcgea_pkg::in_req_t req,
  input  tcgea_pkg::cfg_t    cfg,
  output tcgea_pkg::out_rsp_t rsp
);
  import tcgea_pkg::*;

  localparam int CW    = COUNT_BITS;
  localparam int CMP_W = (COUNT_BITS > 8) ? COUNT_BITS : 8;
  localparam logic [CW-1:0]    CNT_MAX  = {CW{1'b1}};
  localparam logic [CMP_W-1:0] WAKE_TOP = CMP_W'(255);

  logic [CW-1:0] inside_a_r, inside_a_nxt;
  logic [CW-1:0] inside_b_r, inside_b_nxt;
  logic [CW-1:0] waiting_a_r, waiting_a_nxt;
  logic [CW-1:0] waiting_b_r, waiting_b_nxt;
  logic [CW-1:0] streak_a_r, streak_a_nxt;
  logic [CW-1:0] streak_b_r, streak_b_nxt;
  logic [1:0]    owner_r, owner_nxt;
  logic          turn_is_b_r, turn_is_b_nxt;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + CW'(1);
  endfunction

  logic          is_b;
  logic [CW-1:0] mine, other_in, my_streak, other_wait;
  logic [1:0]    me, them;
  logic          owner_ok, blocked, allowed, no_room;
  logic          wa, wb, a_hit, b_hit, pick_b;
  logic [CMP_W-1:0] wake_x;

  always_comb begin
    is_b       = req.group;
    mine       = is_b ? inside_b_r : inside_a_r;
    other_in   = is_b ? inside_a_r : inside_b_r;
    my_streak  = is_b ? streak_b_r : streak_a_r;
    other_wait = is_b ? waiting_a_r : waiting_b_r;
    me         = is_b ? OWN_B : OWN_A;
    them       = is_b ? OWN_A : OWN_B;

    owner_ok = (owner_r == OWN_NONE) || (owner_r == me);
    blocked  = (CMP_W'(my_streak) >= CMP_W'(cfg.streak_limit)) && (other_wait != '0) &&
               (owner_r != them);
    allowed  = owner_ok && (other_in == '0) && !blocked;
    no_room  = (CMP_W'(mine) >= CMP_W'(cfg.capacity)) || (mine == CNT_MAX);

    wa     = waiting_a_r != '0;
    wb     = waiting_b_r != '0;
    a_hit  = CMP_W'(streak_a_r) >= CMP_W'(cfg.streak_limit);
    b_hit  = CMP_W'(streak_b_r) >= CMP_W'(cfg.streak_limit);
    // Both waiting: the class that has hit its streak limit yields,
    // otherwise the turn bit decides.
    if (wb && !wa) begin
      pick_b = 1'b1;
    end else if (wa && !wb) begin
      pick_b = 1'b0;
    end else if (a_hit != b_hit) begin
      pick_b = a_hit;
    end else begin
      pick_b = turn_is_b_r;
    end
    wake_x = CMP_W'(pick_b ? waiting_b_r : waiting_a_r);

    inside_a_nxt  = inside_a_r;
    inside_b_nxt  = inside_b_r;
    waiting_a_nxt = waiting_a_r;
    waiting_b_nxt = waiting_b_r;
    streak_a_nxt  = streak_a_r;
    streak_b_nxt  = streak_b_r;
    owner_nxt     = owner_r;
    turn_is_b_nxt = turn_is_b_r;
    rsp.status     = ST_GRANTED;
    rsp.wake_group = OWN_NONE;
    rsp.wake_count = 8'd0;

    if (req.operation == OP_ENTER) begin
      if (!allowed) begin
        rsp.status = ST_QUEUED;
        if (is_b) begin
          waiting_b_nxt = sat_inc(waiting_b_r);
        end else begin
          waiting_a_nxt = sat_inc(waiting_a_r);
        end
      end else if (no_room) begin
        rsp.status = ST_FULL;
      end else begin
        owner_nxt = me;
        if (is_b) begin
          inside_b_nxt = mine + CW'(1);
          streak_b_nxt = sat_inc(streak_b_r);
          streak_a_nxt = '0;
        end else begin
          inside_a_nxt = mine + CW'(1);
          streak_a_nxt = sat_inc(streak_a_r);
          streak_b_nxt = '0;
        end
      end
    end else if (mine == '0) begin
      rsp.status = ST_LEAVE_ERR;
    end else begin
      rsp.status = ST_LEFT;
      if (is_b) begin
        inside_b_nxt = mine - CW'(1);
      end else begin
        inside_a_nxt = mine - CW'(1);
      end
      // Last one out: hand the resource over or release ownership.
      if ((mine == CW'(1)) && (other_in == '0)) begin
        streak_a_nxt = '0;
        streak_b_nxt = '0;
        if (!wa && !wb) begin
          owner_nxt = OWN_NONE;
        end else begin
          owner_nxt      = pick_b ? OWN_B : OWN_A;
          turn_is_b_nxt  = !pick_b;
          rsp.wake_group = pick_b ? OWN_B : OWN_A;
          rsp.wake_count = (wake_x > WAKE_TOP) ? 8'hFF : wake_x[7:0];
          if (pick_b) begin
            waiting_b_nxt = '0;
          end else begin
            waiting_a_nxt = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_a_r  <= '0;
      inside_b_r  <= '0;
      waiting_a_r <= '0;
      waiting_b_r <= '0;
      streak_a_r  <= '0;
      streak_b_r  <= '0;
      owner_r     <= OWN_NONE;
      turn_is_b_r <= 1'b0;
    end else if (req_accept) begin
      inside_a_r  <= inside_a_nxt;
      inside_b_r  <= inside_b_nxt;
      waiting_a_r <= waiting_a_nxt;
      waiting_b_r <= waiting_b_nxt;
      streak_a_r  <= streak_a_nxt;
      streak_b_r  <= streak_b_nxt;
      owner_r     <= owner_nxt;
      turn_is_b_r <= turn_is_b_nxt;
    end
  end

endmodule

### design/tcgea_out_buf.sv
`timescale 1ns / 1ps

module tcgea_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tcgea_pkg::out_rsp_t push_data,
  input  logic                pop,
  output logic                full,
  output logic                valid,
  output tcgea_pkg::out_rsp_t head
);
  import tcgea_pkg::*;

  // Two entries: head register plus skid slot.
  logic [1:0] cnt_r, cnt_nxt;
  out_rsp_t   slot0_r, slot1_r;

  assign valid = cnt_r != 2'd0;
  assign full  = cnt_r == 2'd2;
  assign head  = slot0_r;

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      slot0_r <= slot1_r;
      if (push && (cnt_r == 2'd1)) begin
        slot0_r <= push_data;
      end else if (push) begin
        slot1_r <= push_data;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        slot0_r <= push_data;
      end else begin
        slot1_r <= push_data;
      end
    end
  end

endmodule

### design/two_class_group_exclusion_arbiter.sv
`timescale 1ns / 1ps

// Two-class group exclusion arbiter. Admits class A and class B users to a
// shared resource of configurable capacity, one class inside at a time, with
// a streak limit so a busy class cannot starve a waiting one. Each request
// (enter or leave) produces exactly one result: granted, queued, full retry,
// left, or leave error; a leave that empties the resource also reports which
// class was woken and how many waiters were released (capped at 255). Woken
// users must send fresh enter requests. Rate: one request per clock while
// in_stall is low. The decision is combinational logic over the counter
// registers, and the result is written into a two-entry output queue at the
// accepting edge, so it is offered on the next cycle when nothing is queued
// ahead of it; in_stall rises only when both entries hold results that have
// not been taken. Counters are COUNT_BITS wide and saturate.
// Configuration (index 0 capacity, reset 4; index 1 streak limit, reset 8) is
// always ready and must be written only while no request is in flight;
// writes to other indexes are ignored. No clearing pass after reset.
module two_class_group_exclusion_arbiter #(
  parameter int COUNT_BITS = tcgea_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  tcgea_pkg::in_req_t                   in_req,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output tcgea_pkg::out_rsp_t                  out_rsp,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tcgea_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcgea_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tcgea_pkg::*;

  cfg_t     cfg_r;
  out_rsp_t rsp;
  logic     buf_full;
  logic     in_acc, out_acc;

  assign cfg_ready = 1'b1;
  assign in_stall  = buf_full;
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.capacity     <= CAPACITY_RST;
      cfg_r.streak_limit <= STREAK_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CAPACITY:     cfg_r.capacity     <= cfg_data;
        CFG_STREAK_LIMIT: cfg_r.streak_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Occupancy, waiter, streak and turn state; decides each request.
  tcgea_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_accept (in_acc),
    .req        (in_req),
    .cfg        (cfg_r),
    .rsp        (rsp)
  );

  // Result register with skid slot, so a stalled result does not hold off
  // the next request.
  tcgea_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .push_data (rsp),
    .pop       (out_acc),
    .full      (buf_full),
    .valid     (out_valid),
    .head      (out_rsp)
  );

endmodule

### design/tcgea_chk.sv
`timescale 1ns / 1ps

module tcgea_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input tcgea_pkg::in_req_t               in_req,
  input logic                             out_valid,
  input logic                             out_stall,
  input tcgea_pkg::out_rsp_t              out_rsp
);
  import tcgea_pkg::*;

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rsp))
    else $error("result changed while stalled");

  // Back-pressure only when results are pending.
  a_stall_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // Only a leave can wake anyone.
  a_wake_on_leave: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rsp.status != ST_LEFT) |-> out_rsp.wake_group == OWN_NONE)
    else $error("wake reported on a non-leave result");

  // No wake, no count.
  a_wake_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rsp.wake_group == OWN_NONE) |-> out_rsp.wake_count == 8'd0)
    else $error("wake count without a woken class");

  // An accepted request shows a result on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted request produced no result");

endmodule

bind two_class_group_exclusion_arbiter tcgea_chk u_chk (.*);

### verif/two_class_group_exclusion_arbiter_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and register channels, predicts each result
// from its own copy of the occupancy state and compares in order.
module two_class_group_exclusion_arbiter_checker #(
  parameter int COUNT_BITS = tcgea_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  tcgea_pkg::in_req_t               in_req,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  tcgea_pkg::out_rsp_t              out_rsp,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [tcgea_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcgea_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                               fail_count,
  output int                               pending
);
  import tcgea_pkg::*;

  localparam int CW = COUNT_BITS;
  localparam logic [CW-1:0] CNT_TOP = '1;

  logic [CFG_DATA_W-1:0] capacity_q;
  logic [CFG_DATA_W-1:0] streak_limit;

  logic [CW-1:0] in_a, in_b;
  logic [CW-1:0] wait_a, wait_b;
  logic [CW-1:0] run_a, run_b;
  logic [1:0]    owner;
  logic          b_turn;

  out_rsp_t rsp_q[$];
  out_rsp_t predicted;
  out_rsp_t oldest;
  int       fails;

  function automatic logic [CW-1:0] bump(input logic [CW-1:0] v);
    return (v == CNT_TOP) ? v : v + 1'b1;
  endfunction

  // Decide one request and update the shadow occupancy state.
  task automatic arbitrate(input in_req_t r, output out_rsp_t rsp);
    logic          is_b;
    logic [CW-1:0] mine, theirs_in, my_run, theirs_wait, woken;
    logic [1:0]    me, them, pick;
    logic          owner_ok, blocked, wa, wb, a_hit, b_hit;
    is_b = r.group;
    rsp = '0;
    woken = '0;
    mine = is_b ? in_b : in_a;
    if (r.operation == OP_ENTER) begin
      theirs_in   = is_b ? in_a : in_b;
      my_run      = is_b ? run_b : run_a;
      theirs_wait = is_b ? wait_a : wait_b;
      me          = is_b ? OWN_B : OWN_A;
      them        = is_b ? OWN_A : OWN_B;
      owner_ok    = (owner == OWN_NONE) || (owner == me);
      blocked     = (my_run >= streak_limit) && (theirs_wait != '0) && (owner != them);
      if (owner_ok && theirs_in == '0 && !blocked) begin
        if (mine >= capacity_q || mine == CNT_TOP) begin
          rsp.status = ST_FULL;
        end else begin
          owner = me;
          if (is_b) begin
            in_b  = mine + 1'b1;
            run_b = bump(run_b);
            run_a = '0;
          end else begin
            in_a  = mine + 1'b1;
            run_a = bump(run_a);
            run_b = '0;
          end
          rsp.status = ST_GRANTED;
        end
      end else begin
        if (is_b) wait_b = bump(wait_b);
        else      wait_a = bump(wait_a);
        rsp.status = ST_QUEUED;
      end
    end else if (mine == '0) begin
      rsp.status = ST_LEAVE_ERR;
    end else begin
      if (is_b) in_b = mine - 1'b1;
      else      in_a = mine - 1'b1;
      rsp.status = ST_LEFT;
      if (in_a == '0 && in_b == '0) begin
        wa = (wait_a != '0);
        wb = (wait_b != '0);
        pick = OWN_NONE;
        if (wb && !wa) begin
          pick = OWN_B;
        end else if (wa && !wb) begin
          pick = OWN_A;
        end else if (wa && wb) begin
          a_hit = (run_a >= streak_limit);
          b_hit = (run_b >= streak_limit);
          if (a_hit && !b_hit)      pick = OWN_B;
          else if (b_hit && !a_hit) pick = OWN_A;
          else                      pick = b_turn ? OWN_B : OWN_A;
        end
        if (pick == OWN_B) begin
          woken  = wait_b;
          wait_b = '0;
          b_turn = 1'b0;
        end else if (pick == OWN_A) begin
          woken  = wait_a;
          wait_a = '0;
          b_turn = 1'b1;
        end
        owner = pick;
        run_a = '0;
        run_b = '0;
        rsp.wake_group = pick;
        rsp.wake_count = (int'(woken) > 255) ? 8'hFF : 8'(woken);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      capacity_q   = CAPACITY_RST;
      streak_limit = STREAK_LIMIT_RST;
      in_a   = '0;
      in_b   = '0;
      wait_a = '0;
      wait_b = '0;
      run_a  = '0;
      run_b  = '0;
      owner  = OWN_NONE;
      b_turn = 1'b0;
      rsp_q.delete();
      fails = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CAPACITY:     capacity_q = cfg_data;
          CFG_STREAK_LIMIT: streak_limit = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        arbitrate(in_req, predicted);
        rsp_q.push_back(predicted);
      end
      if (out_valid && !out_stall) begin
        if (rsp_q.size() == 0) begin
          if (fails < 10)
            $display("unexpected result: status %0d wake_group %0d wake_count %0d",
                     out_rsp.status, out_rsp.wake_group, out_rsp.wake_count);
          fails++;
        end else begin
          oldest = rsp_q.pop_front();
          if (out_rsp.status !== oldest.status ||
              out_rsp.wake_group !== oldest.wake_group ||
              out_rsp.wake_count !== oldest.wake_count) begin
            if (fails < 10)
              $display({"mismatch at %0t (expected/actual): status %0d/%0d ",
                        "wake_group %0d/%0d wake_count %0d/%0d"}, $realtime,
                       oldest.status, out_rsp.status, oldest.wake_group,
                       out_rsp.wake_group, oldest.wake_count, out_rsp.wake_count);
            fails++;
          end
        end
      end
    end
    fail_count <= fails;
    pending    <= rsp_q.size();
  end

endmodule

### verif/two_class_group_exclusion_arbiter_test.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the arbiter. The checker beside the block does all
// prediction; this module only drives requests, register writes and result
// back-pressure, and reports the outcome.
module two_class_group_exclusion_arbiter_test;
  import tcgea_pkg::*;

  localparam logic CLASS_A = 1'b0;
  localparam logic CLASS_B = 1'b1;

  // Unused register indexes, written once to show they are ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  // Cycles with no handshake on any channel before the run is abandoned.
  localparam int STALL_LIMIT = 2000;
  // Length of the one long receiver hold-off.
  localparam int LONG_HOLD = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_req_t               in_req = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_rsp_t              out_rsp;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int sent = 0;
  int quiet_cycles = 0;

  // calm: no idling on either side. hold_req: ask for the long hold-off.
  logic calm = 1'b0;
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  two_class_group_exclusion_arbiter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  two_class_group_exclusion_arbiter_checker arbiter_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_rsp    (out_rsp),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Result back-pressure: random stalls, none while calm, and one long
  // hold-off on request so the output queue fills and in_stall rises.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= LONG_HOLD - 1;
      out_stall  <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 30);
    end
  end

  // Watchdog: abandon the run if no channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One request; valid stays high across back-to-back requests and only
  // drops for a random idle gap.
  task automatic send(input logic op, input logic grp);
    while (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_req.operation <= op;
    in_req.group     <= grp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Stop offering and wait for every outstanding result.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic setup(input logic [CFG_DATA_W-1:0] cap,
                       input logic [CFG_DATA_W-1:0] streak);
    settle();
    write_reg(CFG_CAPACITY, cap);
    write_reg(CFG_STREAK_LIMIT, streak);
  endtask

  // Mostly visits: one class enters and leaves while the other class turns
  // up and gets queued, then the woken class retries and leaves. Some visits
  // are cut short or overrun, and some requests are pure noise.
  task automatic run_traffic(input int n);
    int   goal;
    int   kind;
    int   len;
    int   outs;
    int   guests;
    logic g;
    goal = sent + n;
    while (sent < goal) begin
      kind = $urandom_range(99);
      g = 1'($urandom_range(1));
      if (kind < 15) begin
        send(($urandom_range(99) < 65) ? OP_LEAVE : OP_ENTER, 1'($urandom_range(1)));
      end else begin
        len = $urandom_range(1, 6);
        outs = (kind < 25) ? $urandom_range(0, len + 3) : len;
        guests = 0;
        repeat (len) begin
          send(OP_ENTER, g);
          if ($urandom_range(99) < 30) begin
            send(OP_ENTER, !g);
            guests++;
          end
        end
        repeat (outs) begin
          send(OP_LEAVE, g);
          if ($urandom_range(99) < 20) begin
            send(OP_ENTER, !g);
            guests++;
          end
        end
        // woken waiters come back as fresh enter requests
        repeat (guests) send(OP_ENTER, !g);
        repeat (guests) send(OP_LEAVE, !g);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pass at reset settings (capacity 4, streak limit 8).
    send(OP_LEAVE, CLASS_A);            // leave with nobody inside
    send(OP_LEAVE, CLASS_B);
    repeat (5) send(OP_ENTER, CLASS_A); // four granted, then full retry
    repeat (2) send(OP_ENTER, CLASS_B); // queued behind class A
    repeat (4) send(OP_LEAVE, CLASS_A); // last leave wakes both B waiters
    send(OP_ENTER, CLASS_B);
    send(OP_ENTER, CLASS_A);            // queued behind class B
    send(OP_LEAVE, CLASS_B);            // wakes the single A waiter
    send(OP_ENTER, CLASS_A);
    send(OP_LEAVE, CLASS_A);            // empties with nobody waiting

    // Saturation sweep from an empty resource at the widest settings.
    setup(8'd255, 8'd255);
    repeat (258) send(OP_ENTER, CLASS_A); // inside and streak climb to the top
    repeat (3) begin                      // streak stays at its top value
      send(OP_LEAVE, CLASS_A);
      send(OP_ENTER, CLASS_A);
    end
    repeat (258) send(OP_ENTER, CLASS_B); // waiter count saturates
    repeat (256) send(OP_LEAVE, CLASS_A); // wake of a saturated count
    run_traffic(80);

    setup(8'd1, 8'd1);
    run_traffic(140);

    // Zero capacity and zero streak limit, plus writes to unused indexes.
    setup(8'd0, 8'd0);
    write_reg(CFG_SPARE_LO, 8'($urandom_range(255)));
    write_reg(CFG_SPARE_HI, 8'($urandom_range(255)));
    run_traffic(40);

    // Long result hold-off while requests keep coming.
    setup(8'd3, 8'd2);
    hold_req <= 1'b1;
    run_traffic(250);

    setup(8'd2, 8'd0);
    run_traffic(120);

    // A stretch with no idling on either side.
    setup(8'd255, 8'd1);
    calm <= 1'b1;
    run_traffic(150);
    calm <= 1'b0;

    setup(CAPACITY_RST, STREAK_LIMIT_RST);
    run_traffic(220);

    settle();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
